### rtl/core/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

   localparam int WORD_WIDTH = 16;
   localparam int PROD_WIDTH = 2 * WORD_WIDTH;
   localparam int STEP_WIDTH = $clog2(PROD_WIDTH);
   localparam int BYTE_WIDTH = 8;
   localparam int CSR_ADDR_WIDTH = 2;

   localparam logic [WORD_WIDTH-1:0] PUB_EXP_RESET  = WORD_WIDTH'(6239);
   localparam logic [WORD_WIDTH-1:0] PRIV_EXP_RESET = WORD_WIDTH'(3119);
   localparam logic [WORD_WIDTH-1:0] MODULUS_RESET  = WORD_WIDTH'(34393);

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_PUB_EXP  = 2'd0,
      CSR_PRIV_EXP = 2'd1,
      CSR_MODULUS  = 2'd2
   } csr_addr_type;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   // operand pair fed to the multiplier ahead of the reducer
   typedef enum logic [1:0] {
      SRC_BASE = 2'd0,
      SRC_MUL  = 2'd1,
      SRC_SQR  = 2'd2
   } red_src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE_GO,
      ST_BASE_WAIT,
      ST_CHECK,
      ST_LOOP,
      ST_MUL_WAIT,
      ST_SQR_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        load_item;
      logic        red_start;
      red_src_type red_src;
      logic        upd_base;
      logic        upd_acc;
      logic        shift_exp;
      logic        clear_acc;
      logic        write_out;
   } cmd_type;

   typedef struct packed {
      logic red_done;
      logic base_zero;
      logic mod_zero;
      logic exp_zero;
      logic exp_bit0;
      logic out_full;
   } sts_type;

endpackage

### rtl/core/mexp_modred.sv
// Bit-serial restoring reduction of a double-width product modulo the modulus.
module mexp_modred
   import mexp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [PROD_WIDTH-1:0] x_in,
   input  logic [WORD_WIDTH-1:0] modulus,
   output logic                  done,
   output logic [WORD_WIDTH-1:0] remainder
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_WIDTH-1:0] cnt_ff, cnt_in;
   logic [PROD_WIDTH-1:0] x_ff, x_in_nxt;
   logic [WORD_WIDTH-1:0] rem_ff, rem_in;
   logic [WORD_WIDTH:0]   trial;
   logic [WORD_WIDTH:0]   diff;
   logic                  last_step;

   assign trial     = {rem_ff, x_ff[PROD_WIDTH-1]};
   assign diff      = trial - {1'b0, modulus};
   assign last_step = (cnt_ff == STEP_WIDTH'(PROD_WIDTH - 1));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      x_in_nxt = x_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         x_in_nxt = x_in;
         rem_in   = '0;
      end else if (busy_ff) begin
         // remainder stays below the modulus, so one trial subtract per bit
         rem_in   = (trial >= {1'b0, modulus}) ? diff[WORD_WIDTH-1:0]
                                               : trial[WORD_WIDTH-1:0];
         x_in_nxt = {x_ff[PROD_WIDTH-2:0], 1'b0};
         cnt_in   = cnt_ff + STEP_WIDTH'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in_nxt;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### rtl/core/mexp_datapath.sv
// Datapath: config registers, working registers, multiplier, reducer, output register.
module mexp_datapath
   import mexp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [WORD_WIDTH-1:0]     csr_wdata,
   input  logic [WORD_WIDTH-1:0]     req_tdata,
   input  logic                      req_tuser,
   input  logic                      req_tlast,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output logic [WORD_WIDTH-1:0]     rsp_tdata,
   output logic                      rsp_tlast,
   input  cmd_type                   cmd,
   output sts_type                   sts
);

   logic [WORD_WIDTH-1:0] pub_exp_ff, priv_exp_ff, modulus_ff;
   logic [WORD_WIDTH-1:0] base_ff, base_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [WORD_WIDTH-1:0] exp_ff, exp_in;
   logic                  op_ff, last_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0] rsp_data_ff;
   logic                  rsp_last_ff;
   logic [WORD_WIDTH-1:0] mul_a, mul_b;
   logic [PROD_WIDTH-1:0] red_x;
   logic                  red_done;
   logic [WORD_WIDTH-1:0] red_rem;
   logic [WORD_WIDTH-1:0] out_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         pub_exp_ff  <= PUB_EXP_RESET;
         priv_exp_ff <= PRIV_EXP_RESET;
         modulus_ff  <= MODULUS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PUB_EXP:  pub_exp_ff  <= csr_wdata;
            CSR_PRIV_EXP: priv_exp_ff <= csr_wdata;
            CSR_MODULUS:  modulus_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // operand select; the product is registered inside the reducer on start
   always_comb begin
      case (cmd.red_src)
         SRC_MUL: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
         SRC_SQR: begin
            mul_a = base_ff;
            mul_b = base_ff;
         end
         default: begin
            mul_a = base_ff;
            mul_b = WORD_WIDTH'(1);
         end
      endcase
      red_x = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
   end

   mexp_modred u_modred (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.red_start),
      .x_in      (red_x),
      .modulus   (modulus_ff),
      .done      (red_done),
      .remainder (red_rem)
   );

   always_comb begin
      base_in = base_ff;
      acc_in  = acc_ff;
      exp_in  = exp_ff;
      if (cmd.load_item) begin
         base_in = req_tdata;
         acc_in  = WORD_WIDTH'(1);
         exp_in  = (req_tuser == OP_DECRYPT) ? priv_exp_ff : pub_exp_ff;
      end else begin
         if (cmd.upd_base)  base_in = red_rem;
         if (cmd.upd_acc)   acc_in  = red_rem;
         if (cmd.clear_acc) acc_in  = '0;
         if (cmd.shift_exp) exp_in  = {1'b0, exp_ff[WORD_WIDTH-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      acc_ff  <= acc_in;
      exp_ff  <= exp_in;
      if (cmd.load_item) begin
         op_ff   <= req_tuser;
         last_ff <= req_tlast;
      end
   end

   // decrypt results keep only the low byte
   assign out_value = (op_ff == OP_DECRYPT)
                      ? {{(WORD_WIDTH-BYTE_WIDTH){1'b0}}, acc_ff[BYTE_WIDTH-1:0]}
                      : acc_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.write_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_out) begin
         rsp_data_ff <= out_value;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign sts.red_done  = red_done;
   assign sts.base_zero = (base_ff == '0);
   assign sts.mod_zero  = (modulus_ff == '0);
   assign sts.exp_zero  = (exp_ff == '0);
   assign sts.exp_bit0  = exp_ff[0];
   assign sts.out_full  = rsp_valid_ff & ~rsp_tready;

endmodule

### rtl/core/mexp_ctrl.sv
// Controller state machine sequencing square-and-multiply over the datapath.
module mexp_ctrl
   import mexp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_BASE_GO;
         ST_BASE_GO:   state_in = ST_BASE_WAIT;
         ST_BASE_WAIT: if (sts.red_done) state_in = ST_CHECK;
         ST_CHECK:     state_in = (sts.mod_zero || sts.base_zero) ? ST_FINISH : ST_LOOP;
         ST_LOOP: begin
            if (sts.exp_zero)      state_in = ST_FINISH;
            else if (sts.exp_bit0) state_in = ST_MUL_WAIT;
            else                   state_in = ST_SQR_WAIT;
         end
         ST_MUL_WAIT:  if (sts.red_done) state_in = ST_SQR_WAIT;
         ST_SQR_WAIT:  if (sts.red_done) state_in = ST_LOOP;
         ST_FINISH:    if (!sts.out_full) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.red_src = SRC_BASE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_BASE_GO: begin
            cmd.red_start = 1'b1;
            cmd.red_src   = SRC_BASE;
         end
         ST_BASE_WAIT: cmd.upd_base = sts.red_done;
         ST_CHECK:     cmd.clear_acc = sts.mod_zero | sts.base_zero;
         ST_LOOP: begin
            if (!sts.exp_zero) begin
               cmd.red_start = 1'b1;
               cmd.red_src   = sts.exp_bit0 ? SRC_MUL : SRC_SQR;
            end
         end
         ST_MUL_WAIT: begin
            // square starts as soon as the product is folded into the accumulator
            cmd.upd_acc   = sts.red_done;
            cmd.red_start = sts.red_done;
            cmd.red_src   = SRC_SQR;
         end
         ST_SQR_WAIT: begin
            cmd.upd_base  = sts.red_done;
            cmd.shift_exp = sts.red_done;
         end
         ST_FINISH:    cmd.write_out = ~sts.out_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/modular_exponentiation.sv
// Top level of the modular exponentiation block.
//
//   channel | ports     | payload
//   --------+-----------+------------------------------------------------
//   request | req_t*    | tdata: value[15:0]; tuser: op; tlast: last_in
//   result  | rsp_t*    | tdata: result[15:0]; tlast: last_out
//   config  | csr_*     | addr 0 public exp, 1 private exp, 2 modulus
//
// One item at a time. Each item is loaded, its base is reduced and checked, then per
// exponent bit up to its most significant one: a loop step and a square, with a
// multiply ahead of the square when the bit is set; a zero modulus or base skips the
// loop. The item ends with the result written to the output register. The bit-serial
// reducer yields one remainder bit per cycle over a 32-bit product.
// Reset is synchronous and restores the register defaults. A stalled result waits
// in the output register while the next item is taken and worked on.
module modular_exponentiation
   import mexp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [WORD_WIDTH-1:0]     csr_wdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [WORD_WIDTH-1:0]     req_tdata,   // [15:0] value
   input  logic                      req_tuser,   // [0] op
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [WORD_WIDTH-1:0]     rsp_tdata,   // [15:0] result
   output logic                      rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   mexp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mexp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

### rtl/core/mexp_checker.sv
// Port-level checks for the modular exponentiation block, bound to the top level.
module mexp_checker
   import mexp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [WORD_WIDTH-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("not ready after reset");

   // ready is low right after an accepted item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
